// ===== rtl/nrgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrgd_pkg: shared types and constants of the nibble RLE glyph decoder
// Item and result payloads, and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package nrgd_pkg;

    localparam logic [3:0] NIB_BG_RUN = 4'h0;   // background run opener
    localparam logic [3:0] NIB_FG_RUN = 4'hF;   // foreground run opener
    localparam logic [3:0] FG_SHADE   = 4'd12;
    localparam logic [3:0] BG_SHADE   = 4'd0;
    localparam int unsigned RUN_BIAS  = 3;      // run length is count nibble + 3
    localparam int unsigned LEN_W     = 5;      // holds run length minus one (max 17)

    typedef struct packed {
        logic        glyph_start;
        logic [15:0] token_count;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [3:0] shade;
        logic       palette_white;
        logic       last_of_byte;
        logic       end_of_glyph;
        logic       bad_count;
    } result_t;

    // One stretch of equal pixels: a single pixel or a whole run
    typedef struct packed {
        logic             valid;
        logic [3:0]       shade;
        logic [LEN_W-1:0] len_m1;
        logic             eog;
    } segment_t;

    // All the work one input byte causes: at most two segments
    typedef struct packed {
        segment_t seg_a;
        segment_t seg_b;
        logic     bad;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/nibble_rle_glyph_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_rle_glyph_decoder_core: 4-bit antialiased glyph RLE decoder
// Turns packed glyph bytes into a stream of shaded pixels.
// ----------------------------------------------------------------------------
// Glyph data goes in one byte per transfer; the first byte of each glyph
// carries its token count. Each byte yields between zero and nineteen pixel
// results, one result per cycle at best: two single pixels give two results,
// a byte closing a run of n+3 pixels gives n+3, and a byte that yields nothing
// is taken at the input and never queued. The output pixel rate (one per cycle
// out of the back expander, while pop keeps up) sets the throughput; the front
// classifies a whole byte combinationally and runs ahead by up to QUEUE_DEPTH
// queued bytes. A zero token count gives one error result. The palette flag is
// sampled from on_white as each pixel leaves; write it only when idle.
// ----------------------------------------------------------------------------
module nibble_rle_glyph_decoder_core
    import nrgd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    // byte input
    input  wire logic   push,
    output logic        full,
    input  wire item_t  item,
    // pixel output
    output logic        empty,
    input  wire logic   pop,
    output result_t     result,
    // palette register
    input  wire logic   cfg_valid,
    output logic        cfg_ready,
    input  wire logic   cfg_data
);

    logic   on_white_reg;
    logic   accept;
    entry_t entry;
    logic   entry_valid;
    logic   q_full, q_empty, q_pop;
    entry_t q_data;

    // Always take palette writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            on_white_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            on_white_reg <= cfg_data;
    end

    // Accept a byte whenever the queue has room; bytes without work are dropped
    assign full   = q_full;
    assign accept = push && !q_full;

    nrgd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .entry       (entry),
        .entry_valid (entry_valid)
    );

    nrgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && entry_valid),
        .wr_data (entry),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    nrgd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .on_white (on_white_reg),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
`default_nettype wire

// ===== rtl/nrgd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrgd_front: byte classifier
// Splits each byte into nibbles, tracks token count and pending runs, and
// turns the byte into a queue entry of up to two segments.
// ----------------------------------------------------------------------------
module nrgd_front
    import nrgd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   accept,
    input  wire item_t  item,
    output entry_t      entry,
    output logic        entry_valid
);

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_BG   = 2'd1,
        RUN_FG   = 2'd2
    } run_t;

    run_t        pending_reg, pending_next;
    logic [15:0] tokens_reg, tokens_next;
    logic        active_reg, active_next;

    run_t        pr0, pr1;
    logic [15:0] tl0, tl1, dec1, dec2;
    logic        ga0, ga1, bad, used1;
    logic [3:0]  hi_nib, lo_nib;

    always_comb
    begin
        hi_nib = item.data_byte[7:4];
        lo_nib = item.data_byte[3:0];
        bad    = item.glyph_start && (item.token_count == 16'd0);
        pr0    = item.glyph_start ? RUN_NONE : pending_reg;
        tl0    = item.glyph_start ? item.token_count : tokens_reg;
        ga0    = item.glyph_start ? !bad : active_reg;
        dec1   = tl0 - 16'd1;
        dec2   = tl0 - 16'd2;

        entry        = '0;
        pr1          = pr0;
        tl1          = tl0;
        ga1          = ga0;
        used1        = 1'b0;
        pending_next = pr0;
        tokens_next  = tl0;
        active_next  = ga0;

        if (bad)
        begin
            // one error result, data byte dropped
            entry.bad          = 1'b1;
            entry.seg_a.valid  = 1'b1;
            entry.seg_a.shade  = BG_SHADE;
            entry.seg_a.len_m1 = '0;
            tokens_next        = '0;
        end
        else if (ga0)
        begin
            // upper nibble
            if (pr0 != RUN_NONE)
            begin
                entry.seg_a.valid  = 1'b1;
                entry.seg_a.shade  = (pr0 == RUN_FG) ? FG_SHADE : BG_SHADE;
                entry.seg_a.len_m1 = LEN_W'(hi_nib) + LEN_W'(RUN_BIAS - 1);
                used1 = 1'b1;
                pr1   = RUN_NONE;
            end
            else if (hi_nib == NIB_BG_RUN)
                pr1 = RUN_BG;
            else if (hi_nib == NIB_FG_RUN)
                pr1 = RUN_FG;
            else
            begin
                entry.seg_a.valid  = 1'b1;
                entry.seg_a.shade  = hi_nib;
                entry.seg_a.len_m1 = '0;
                used1 = 1'b1;
            end
            if (used1)
            begin
                tl1               = dec1;
                ga1               = (dec1 != 16'd0);
                entry.seg_a.eog   = (dec1 == 16'd0);
            end

            pending_next = pr1;
            tokens_next  = tl1;
            active_next  = ga1;

            // lower nibble, skipped once the glyph has ended
            if (ga1)
            begin
                if (pr1 != RUN_NONE)
                begin
                    entry.seg_b.valid  = 1'b1;
                    entry.seg_b.shade  = (pr1 == RUN_FG) ? FG_SHADE : BG_SHADE;
                    entry.seg_b.len_m1 = LEN_W'(lo_nib) + LEN_W'(RUN_BIAS - 1);
                    pending_next       = RUN_NONE;
                end
                else if (lo_nib == NIB_BG_RUN)
                    pending_next = RUN_BG;
                else if (lo_nib == NIB_FG_RUN)
                    pending_next = RUN_FG;
                else
                begin
                    entry.seg_b.valid  = 1'b1;
                    entry.seg_b.shade  = lo_nib;
                    entry.seg_b.len_m1 = '0;
                end
                if (entry.seg_b.valid)
                begin
                    tokens_next     = used1 ? dec2 : dec1;
                    active_next     = (tokens_next != 16'd0);
                    entry.seg_b.eog = (tokens_next == 16'd0);
                end
            end
            if (!active_next)
                pending_next = RUN_NONE;
        end

        entry_valid = entry.seg_a.valid || entry.seg_b.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= RUN_NONE;
            tokens_reg  <= '0;
            active_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            tokens_reg  <= tokens_next;
            active_reg  <= active_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nrgd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrgd_queue: entry queue between front and back
// Small first-in first-out store of per-byte work entries.
// ----------------------------------------------------------------------------
module nrgd_queue
    import nrgd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire entry_t wr_data,
    output logic        q_full,
    input  wire logic   rd_en,
    output entry_t      rd_data,
    output logic        q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (rd_en)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (wr_en && !rd_en)
                count_reg <= count_reg + CNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nrgd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrgd_back: pixel expander
// Takes entries from the queue and emits one pixel per cycle into the
// output register, whenever that register is empty or being popped.
// ----------------------------------------------------------------------------
module nrgd_back
    import nrgd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   on_white,
    input  wire logic   q_empty,
    input  wire entry_t q_data,
    output logic        q_pop,
    output result_t     result,
    output logic        empty,
    input  wire logic   pop
);

    entry_t           cur_reg;
    logic             cur_valid_reg;
    logic             sel_reg;
    logic [LEN_W-1:0] cnt_reg;
    result_t          result_reg;
    logic             out_valid_reg;

    segment_t seg;
    logic     seg_done, entry_done, advance, emit;

    always_comb
    begin
        seg        = sel_reg ? cur_reg.seg_b : cur_reg.seg_a;
        seg_done   = (cnt_reg == '0);
        entry_done = seg_done && (sel_reg || !cur_reg.seg_b.valid);
        advance    = !out_valid_reg || pop;
        emit       = cur_valid_reg && advance;
        q_pop      = !q_empty && (!cur_valid_reg || (emit && entry_done));
    end

    assign result = result_reg;
    assign empty  = !out_valid_reg;

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.shade         <= seg.shade;
            result_reg.palette_white <= on_white;
            result_reg.last_of_byte  <= entry_done;
            result_reg.end_of_glyph  <= seg.eog && seg_done;
            result_reg.bad_count     <= cur_reg.bad;
        end
        if (q_pop)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= emit;
            if (emit)
            begin
                if (!seg_done)
                    cnt_reg <= cnt_reg - LEN_W'(1);
                else if (!entry_done)
                begin
                    // move on to the second segment
                    sel_reg <= 1'b1;
                    cnt_reg <= cur_reg.seg_b.len_m1;
                end
                else if (!q_pop)
                    cur_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                sel_reg       <= !q_data.seg_a.valid;
                cnt_reg       <= q_data.seg_a.valid ? q_data.seg_a.len_m1
                                                    : q_data.seg_b.len_m1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nrgd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrgd_checker: port-level checks of the glyph decoder
// Watches the result stream for properties of decoded pixels.
// ----------------------------------------------------------------------------
module nrgd_checker
    import nrgd_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // hold a waiting result until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before transfer");

    // the error result is a lone background result closing its byte
    a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.bad_count) |->
            (result.shade == BG_SHADE && result.last_of_byte && !result.end_of_glyph))
        else $error("malformed error result");

    // the final pixel of a glyph always closes its byte
    a_eog_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.end_of_glyph) |-> result.last_of_byte)
        else $error("end of glyph not last of byte");

    // the foreground run opener code never appears as a shade
    a_shade: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.shade != NIB_FG_RUN))
        else $error("illegal shade");

endmodule

bind nibble_rle_glyph_decoder_core nrgd_checker u_nrgd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the nibble RLE glyph decoder core
// Feeds packed glyph bytes through the input queue, works out the pixels that
// each accepted byte must give, and compares every popped pixel with them.
// ----------------------------------------------------------------------------
module tb;
    import nrgd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000; // run is abandoned past this
    localparam int unsigned SETTLE_CYCLES = 32;     // covers bytes still in the core
    localparam int unsigned PHASE_ITEMS   = 34;     // least glyph bytes sent per palette phase

    // what a run opener nibble left behind, waiting for its count nibble
    typedef enum logic [1:0] {OPEN_NONE, OPEN_BG, OPEN_FG} open_run_e;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_data;

    // decoder state as the bench sees it
    open_run_e   open_run;
    logic [15:0] tokens_left;
    logic        glyph_live;
    logic        palette_white;

    // pixels still owed by the core, oldest first
    result_t     expected_pixels[$];

    int unsigned mismatches;
    int unsigned cycles;
    int unsigned burst_left;
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned mode_timer;

    nibble_rle_glyph_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Pixel prediction
    // ------------------------------------------------------------------------

    // Use up one token; tell whether the glyph has just ended.
    function automatic logic take_token();
        tokens_left = tokens_left - 16'd1;
        if (tokens_left == 16'd0)
        begin
            glyph_live = 1'b0;
            open_run   = OPEN_NONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void owe_pixel(logic [3:0] shade, logic eog, logic bad);
        result_t px;
        px.shade         = shade;
        px.palette_white = palette_white;
        px.last_of_byte  = 1'b0;
        px.end_of_glyph  = eog;
        px.bad_count     = bad;
        expected_pixels.push_back(px);
    endfunction

    // Work out every pixel one accepted byte gives and queue them.
    function automatic void decode_byte(item_t it);
        logic [3:0]  nib;
        logic [3:0]  shade;
        logic        ended;
        int unsigned run_len;
        int          queued_before;
        queued_before = expected_pixels.size();
        if (it.glyph_start)
        begin
            // a new glyph drops whatever was left of the old one
            open_run = OPEN_NONE;
            if (it.token_count == 16'd0)
            begin
                tokens_left = 16'd0;
                glyph_live  = 1'b0;
                owe_pixel(BG_SHADE, 1'b0, 1'b1);
                expected_pixels[$].last_of_byte = 1'b1;
                return;
            end
            tokens_left = it.token_count;
            glyph_live  = 1'b1;
        end
        if (!glyph_live)
            return;
        for (int half = 0; half < 2 && glyph_live; half++)
        begin
            nib = (half == 0) ? it.data_byte[7:4] : it.data_byte[3:0];
            if (open_run != OPEN_NONE)
            begin
                // this nibble is the count of a run opened earlier
                shade    = (open_run == OPEN_FG) ? FG_SHADE : BG_SHADE;
                run_len  = nib + RUN_BIAS;
                open_run = OPEN_NONE;
                ended    = take_token();
                for (int i = 0; i < run_len; i++)
                    owe_pixel(shade, ended && (i == run_len - 1), 1'b0);
            end
            else if (nib == NIB_BG_RUN)
                open_run = OPEN_BG;
            else if (nib == NIB_FG_RUN)
                open_run = OPEN_FG;
            else
            begin
                ended = take_token();
                owe_pixel(nib, ended, 1'b0);
            end
        end
        if (expected_pixels.size() > queued_before)
            expected_pixels[$].last_of_byte = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel checking and the receiver's stall pattern
    // ------------------------------------------------------------------------

    function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_pixel(result_t got);
        result_t want;
        if (expected_pixels.size() == 0)
        begin
            $display("%0t ns: unexpected pixel, expected none, got shade=%0d bad=%0b",
                     $time, got.shade, got.bad_count);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("shade", want.shade, got.shade);
        compare_field("palette_white", want.palette_white, got.palette_white);
        compare_field("last_of_byte", want.last_of_byte, got.last_of_byte);
        compare_field("end_of_glyph", want.end_of_glyph, got.end_of_glyph);
        compare_field("bad_count", want.bad_count, got.bad_count);
    endfunction

    // Check each pixel transfer, then pick pop for the next edge. The mode
    // switches now and then between no stalls, short stalls and long ones.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_pixel(result);
            if (mode_timer == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_timer = $urandom_range(20, 120);
            end
            else
                mode_timer--;
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (stall_mode == 1 && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 19);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Abandon a run that has hung.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until the core takes it, then predict its pixels.
    // Most bursts end with a random gap, with push dropped for its length.
    task automatic send_byte(input logic start, input logic [15:0] count,
                             input logic [7:0] data);
        item_t it;
        it.glyph_start = start;
        it.token_count = count;
        it.data_byte   = data;
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_byte(it);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // Hold off the input until every owed pixel has come out and the core has
    // had time to swallow bytes that give nothing.
    task automatic drain();
        push <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the palette flag; call only with the core idle.
    task automatic write_palette(input logic on_white);
        cfg_data  <= on_white;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        palette_white = on_white;
    endtask

    function automatic logic [3:0] pick_nibble();
        case ($urandom_range(0, 9))
            0, 1:    return NIB_BG_RUN;
            2, 3:    return NIB_FG_RUN;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero count error, the largest count, and every single-pixel shade.
    task automatic test_counts_and_shades();
        send_byte(1'b1, 16'h0000, 8'hFF);
        send_byte(1'b1, 16'hFFFF, 8'h12);
        send_byte(1'b0, 16'h5555, 8'h34);
        send_byte(1'b0, 16'hAAAA, 8'h56);
        send_byte(1'b0, 16'h0000, 8'h78);
        send_byte(1'b0, 16'hFFFF, 8'h9A);
        send_byte(1'b0, 16'h0000, 8'hBC);
        send_byte(1'b0, 16'h0000, 8'hDE);
    endtask

    // Runs at both extreme lengths, within a byte and across two bytes.
    task automatic test_runs();
        send_byte(1'b0, 16'h0000, 8'h0F);   // longest background run
        send_byte(1'b0, 16'h0000, 8'hF0);   // shortest foreground run
        send_byte(1'b0, 16'h0000, 8'h10);   // pixel, then a run opens at the byte end
        send_byte(1'b0, 16'h0000, 8'h5F);   // run closes, another opens
        send_byte(1'b0, 16'h0000, 8'hFF);   // foreground run closes, fresh one opens
    endtask

    // Glyph edges: restarts, endings inside a byte, bytes past the end.
    task automatic test_glyph_edges();
        send_byte(1'b1, 16'd2, 8'hF0);      // restart drops the open run
        send_byte(1'b0, 16'd0, 8'h00);      // glyph ends on a run
        send_byte(1'b0, 16'd9, 8'h77);      // past the end: nothing
        send_byte(1'b1, 16'd1, 8'h9C);      // ends on the upper nibble
        send_byte(1'b1, 16'd3, 8'h20);      // pixel, background run opens
        send_byte(1'b0, 16'd0, 8'hF1);      // longest run plus a pixel: most pixels
        send_byte(1'b1, 16'd5, 8'hEF);      // pixel, foreground run opens
        send_byte(1'b1, 16'd0, 8'h00);      // zero count mid-glyph
        send_byte(1'b0, 16'd4, 8'h11);      // nothing live: ignored
    endtask

    // One glyph of random make-up: mostly well-formed, some cut short, some
    // with bad or huge counts, some trailed by extra bytes, ignored once it has ended.
    task automatic send_random_glyph(inout int unsigned sent);
        logic [15:0] count;
        int unsigned max_bytes;
        int unsigned n;
        case ($urandom_range(0, 9))
            0:       count = 16'd0;
            1:       count = 16'($urandom_range(0, 65535));
            default: count = 16'($urandom_range(1, 10));
        endcase
        max_bytes = (count > 16'd20) ? $urandom_range(1, 8) : 2 * count + 2;
        n = 0;
        send_byte(1'b1, count, {pick_nibble(), pick_nibble()});
        sent++;
        while (glyph_live && n < max_bytes)
        begin
            if ($urandom_range(0, 19) == 0)
                return;                     // break off: the next glyph restarts
            send_byte(1'b0, 16'($urandom_range(0, 65535)), {pick_nibble(), pick_nibble()});
            sent++;
            n++;
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
            begin
                send_byte(1'b0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                sent++;
            end
    endtask

    // Random glyphs over several palette settings; now and then wait for the
    // core to run dry before going on.
    task automatic test_random_glyphs();
        int unsigned sent;
        logic        settings[4];
        settings = '{1'b1, 1'b0, 1'b1, 1'b0};
        settings[3] = 1'($urandom_range(0, 1));
        foreach (settings[p])
        begin
            drain();
            write_palette(settings[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_glyph(sent);
                if ($urandom_range(0, 11) == 0)
                    drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        open_run      = OPEN_NONE;
        tokens_left   = 16'd0;
        glyph_live    = 1'b0;
        palette_white = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        burst_left    = 1;
        stall_left    = 0;
        stall_mode    = 0;
        mode_timer    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_counts_and_shades();
        drain();
        write_palette(1'b1);
        test_runs();
        test_glyph_edges();
        test_random_glyphs();
        drain();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
